// ===== design/tilt_gesture_hold_detector_defines.svh =====
// Assertion helpers, included by the design file tgh_back.
`ifndef TILT_GESTURE_HOLD_DETECTOR_DEFINES_SVH
`define TILT_GESTURE_HOLD_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TGH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tgh assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TGH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tgh assertion failed");

`endif

// ===== design/tgh_pkg.sv =====
`timescale 1ns / 1ps
package tgh_pkg;

    localparam int TGH_SAMPLE_W = 16;
    localparam int TGH_THR_W    = 15;
    localparam int TGH_TICK_W   = 8;
    localparam int TGH_IDLE_W   = 16;
    localparam int TGH_HOLD_W   = 9;
    localparam int TGH_DATA_W   = 32;
    localparam int TGH_ADDR_W   = 5;
    localparam int TGH_QDEPTH   = 2;

    localparam logic [TGH_THR_W-1:0]  TGH_RST_REV_THR   = 15'd10000;
    localparam logic [TGH_THR_W-1:0]  TGH_RST_ACCEL_THR = 15'd7000;
    localparam logic [TGH_THR_W-1:0]  TGH_RST_GYRO_THR  = 15'd2000;
    localparam logic [TGH_TICK_W-1:0] TGH_RST_REV_HOLD  = 8'd10;
    localparam logic [TGH_TICK_W-1:0] TGH_RST_SIDE_HOLD = 8'd2;
    localparam logic [TGH_TICK_W-1:0] TGH_RST_FB_HOLD   = 8'd2;
    localparam logic [TGH_IDLE_W-1:0] TGH_RST_IDLE_LIM  = 16'd50;

    typedef enum logic [2:0] {
        G_NONE  = 3'd0,
        G_REV   = 3'd1,
        G_LEFT  = 3'd2,
        G_RIGHT = 3'd3,
        G_FRONT = 3'd4,
        G_BACK  = 3'd5
    } t_gesture;

    typedef enum logic [3:0] {
        A_NONE      = 4'd0,
        A_SETTING   = 4'd1,
        A_PREV      = 4'd2,
        A_NEXT      = 4'd3,
        A_ENTER     = 4'd4,
        A_CTL_LEFT  = 4'd5,
        A_CTL_RIGHT = 4'd6,
        A_CTL_FRONT = 4'd7,
        A_CTL_BACK  = 4'd8,
        A_CLOCK     = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        REG_REV_THR   = 3'd0,
        REG_ACCEL_THR = 3'd1,
        REG_GYRO_THR  = 3'd2,
        REG_REV_HOLD  = 3'd3,
        REG_SIDE_HOLD = 3'd4,
        REG_FB_HOLD   = 3'd5,
        REG_IDLE_LIM  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TGH_THR_W-1:0]  reverse_threshold;
        logic [TGH_THR_W-1:0]  tilt_accel_threshold;
        logic [TGH_THR_W-1:0]  tilt_gyro_threshold;
        logic [TGH_TICK_W-1:0] reverse_hold_ticks;
        logic [TGH_TICK_W-1:0] side_hold_ticks;
        logic [TGH_TICK_W-1:0] front_back_hold_ticks;
        logic [TGH_IDLE_W-1:0] idle_limit;
    } t_cfg;

    // Classified sample as carried from front to back.
    typedef struct packed {
        logic     sample_valid;
        logic     running;
        t_gesture det;
        logic     az_gt;
        logic     ax_gt;
        logic     ax_lt;
        logic     ay_lt;
        logic     ay_gt;
    } t_class;

endpackage

// ===== design/tgh_cfg.sv =====
`timescale 1ns / 1ps
module tgh_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tgh_pkg::TGH_ADDR_W-1:0] paddr,
    input  logic [tgh_pkg::TGH_DATA_W-1:0] pwdata,
    output logic [tgh_pkg::TGH_DATA_W-1:0] prdata,
    output logic                           pready,
    output tgh_pkg::t_cfg                  o_cfg
);
    import tgh_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[TGH_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_threshold     <= TGH_RST_REV_THR;
            r_cfg.tilt_accel_threshold  <= TGH_RST_ACCEL_THR;
            r_cfg.tilt_gyro_threshold   <= TGH_RST_GYRO_THR;
            r_cfg.reverse_hold_ticks    <= TGH_RST_REV_HOLD;
            r_cfg.side_hold_ticks       <= TGH_RST_SIDE_HOLD;
            r_cfg.front_back_hold_ticks <= TGH_RST_FB_HOLD;
            r_cfg.idle_limit            <= TGH_RST_IDLE_LIM;
        end else if (wr_en) begin
            case (idx)
                REG_REV_THR:   r_cfg.reverse_threshold     <= pwdata[TGH_THR_W-1:0];
                REG_ACCEL_THR: r_cfg.tilt_accel_threshold  <= pwdata[TGH_THR_W-1:0];
                REG_GYRO_THR:  r_cfg.tilt_gyro_threshold   <= pwdata[TGH_THR_W-1:0];
                REG_REV_HOLD:  r_cfg.reverse_hold_ticks    <= pwdata[TGH_TICK_W-1:0];
                REG_SIDE_HOLD: r_cfg.side_hold_ticks       <= pwdata[TGH_TICK_W-1:0];
                REG_FB_HOLD:   r_cfg.front_back_hold_ticks <= pwdata[TGH_TICK_W-1:0];
                REG_IDLE_LIM:  r_cfg.idle_limit            <= pwdata[TGH_IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_REV_THR:   prdata = TGH_DATA_W'(r_cfg.reverse_threshold);
            REG_ACCEL_THR: prdata = TGH_DATA_W'(r_cfg.tilt_accel_threshold);
            REG_GYRO_THR:  prdata = TGH_DATA_W'(r_cfg.tilt_gyro_threshold);
            REG_REV_HOLD:  prdata = TGH_DATA_W'(r_cfg.reverse_hold_ticks);
            REG_SIDE_HOLD: prdata = TGH_DATA_W'(r_cfg.side_hold_ticks);
            REG_FB_HOLD:   prdata = TGH_DATA_W'(r_cfg.front_back_hold_ticks);
            REG_IDLE_LIM:  prdata = TGH_DATA_W'(r_cfg.idle_limit);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== design/tgh_front.sv =====
`timescale 1ns / 1ps
module tgh_front (
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_sample_valid,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_x,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_y,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_z,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_gyro_x,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_gyro_y,
    input  logic                             i_widget_running,
    input  tgh_pkg::t_cfg                    i_cfg,
    input  logic                             i_q_full,
    output logic                             o_push,
    output tgh_pkg::t_class                  o_class
);
    import tgh_pkg::*;

    localparam int EXT_W = TGH_SAMPLE_W + 1;

    logic signed [EXT_W-1:0] ax, ay, az, gx, gy;
    logic signed [EXT_W-1:0] rt, at, gt, neg_at, neg_gt;
    logic left_ok, right_ok, front_ok, back_ok;

    // Sign-extend samples and zero-extend thresholds to a common width.
    assign ax = signed'({i_accel_x[TGH_SAMPLE_W-1], i_accel_x});
    assign ay = signed'({i_accel_y[TGH_SAMPLE_W-1], i_accel_y});
    assign az = signed'({i_accel_z[TGH_SAMPLE_W-1], i_accel_z});
    assign gx = signed'({i_gyro_x[TGH_SAMPLE_W-1], i_gyro_x});
    assign gy = signed'({i_gyro_y[TGH_SAMPLE_W-1], i_gyro_y});
    assign rt = signed'({2'b00, i_cfg.reverse_threshold});
    assign at = signed'({2'b00, i_cfg.tilt_accel_threshold});
    assign gt = signed'({2'b00, i_cfg.tilt_gyro_threshold});
    assign neg_at = -at;
    assign neg_gt = -gt;

    assign o_class.sample_valid = i_sample_valid;
    assign o_class.running      = i_widget_running;
    assign o_class.az_gt        = az > rt;
    assign o_class.ax_gt        = ax > at;
    assign o_class.ax_lt        = ax < neg_at;
    assign o_class.ay_lt        = ay < neg_at;
    assign o_class.ay_gt        = ay > at;

    assign left_ok  = o_class.ax_gt && (gy > gt);
    assign right_ok = o_class.ax_lt && (gy < neg_gt);
    assign front_ok = o_class.ay_lt && (gx > neg_gt);
    assign back_ok  = o_class.ay_gt && (gx < gt);

    // Priority: reverse, left, right, front, back.
    always_comb begin
        if (o_class.az_gt) begin
            o_class.det = G_REV;
        end else if (left_ok) begin
            o_class.det = G_LEFT;
        end else if (right_ok) begin
            o_class.det = G_RIGHT;
        end else if (front_ok) begin
            o_class.det = G_FRONT;
        end else if (back_ok) begin
            o_class.det = G_BACK;
        end else begin
            o_class.det = G_NONE;
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// ===== design/tgh_queue.sv =====
`timescale 1ns / 1ps
module tgh_queue #(
    parameter int DEPTH = tgh_pkg::TGH_QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tgh_pkg::t_class i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output tgh_pkg::t_class o_head
);
    import tgh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_class           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/tgh_back.sv =====
`timescale 1ns / 1ps
`include "tilt_gesture_hold_detector_defines.svh"
module tgh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tgh_pkg::t_cfg   i_cfg,
    input  logic            i_q_nonempty,
    input  tgh_pkg::t_class i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_fired_gesture,
    output logic [3:0]      o_action,
    output logic            o_wifi_reset_request,
    output logic [2:0]      o_pending_gesture_out
);
    import tgh_pkg::*;

    t_gesture              r_pending, n_pending;
    logic [TGH_HOLD_W-1:0] r_hold_count, n_hold_count;
    logic [TGH_IDLE_W-1:0] r_idle_count, n_idle_count;
    logic [TGH_IDLE_W-1:0] idle_base, idle_inc;
    logic [TGH_TICK_W-1:0] limit;
    logic                  holding;

    t_gesture n_fired, r_fired;
    t_action  n_action, r_action;
    logic     n_wifi, r_wifi;
    t_gesture r_pend_out;
    logic     r_out_valid;

    // Take the next beat whenever the output slot is free or being drained.
    assign o_pop = i_q_nonempty && (!r_out_valid || !i_stall);

    always_comb begin
        n_pending    = r_pending;
        n_hold_count = r_hold_count;
        idle_base    = r_idle_count;
        n_fired      = G_NONE;
        n_action     = A_NONE;
        n_wifi       = 1'b0;
        holding      = 1'b0;
        limit        = '0;
        if (i_head.sample_valid) begin
            if (r_pending == G_NONE) begin
                n_hold_count = '0;
                n_pending    = i_head.det;
            end else begin
                idle_base = '0;
                case (r_pending)
                    G_REV: begin
                        holding = i_head.az_gt;
                        limit   = i_cfg.reverse_hold_ticks;
                    end
                    G_LEFT: begin
                        holding = i_head.ax_gt;
                        limit   = i_cfg.side_hold_ticks;
                    end
                    G_RIGHT: begin
                        holding = i_head.ax_lt;
                        limit   = i_cfg.side_hold_ticks;
                    end
                    G_FRONT: begin
                        holding = i_head.ay_lt;
                        limit   = i_cfg.front_back_hold_ticks;
                    end
                    G_BACK: begin
                        holding = i_head.ay_gt;
                        limit   = i_cfg.front_back_hold_ticks;
                    end
                    default: begin
                        holding = 1'b0;
                        limit   = '0;
                    end
                endcase
                if (holding) begin
                    n_hold_count = (r_hold_count == '1) ? r_hold_count : r_hold_count + 1'b1;
                    if (r_hold_count >= {1'b0, limit}) begin
                        n_fired   = r_pending;
                        n_pending = G_NONE;
                        case (r_pending)
                            G_REV: begin
                                n_hold_count = '0;
                                n_wifi       = 1'b1;
                                n_action     = A_SETTING;
                            end
                            G_LEFT:  n_action = i_head.running ? A_CTL_LEFT : A_PREV;
                            G_RIGHT: n_action = i_head.running ? A_CTL_RIGHT : A_NEXT;
                            G_FRONT: n_action = i_head.running ? A_CTL_FRONT : A_ENTER;
                            default: n_action = i_head.running ? A_CTL_BACK : A_NONE;
                        endcase
                    end
                end else begin
                    n_pending = G_NONE;
                end
            end
        end
        // Idle step; counter wraps at 16 bits.
        idle_inc     = idle_base + 1'b1;
        n_idle_count = idle_base;
        if (!i_head.running) begin
            n_idle_count = idle_inc;
            if (idle_inc > i_cfg.idle_limit) begin
                n_idle_count = '0;
                if (n_fired == G_NONE) begin
                    n_action = A_CLOCK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= G_NONE;
            r_hold_count <= '0;
            r_idle_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pending    <= n_pending;
                r_hold_count <= n_hold_count;
                r_idle_count <= n_idle_count;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_fired    <= n_fired;
            r_action   <= n_action;
            r_wifi     <= n_wifi;
            r_pend_out <= n_pending;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_fired_gesture       = r_fired;
    assign o_action              = r_action;
    assign o_wifi_reset_request  = r_wifi;
    assign o_pending_gesture_out = r_pend_out;

    `TGH_ASSERT_IMPLIES(a_fire_drops_pending, i_clk, i_rst_n, r_out_valid && (r_fired != G_NONE), r_pend_out == G_NONE)
    `TGH_ASSERT_IMPLIES(a_wifi_only_reverse, i_clk, i_rst_n, r_out_valid && r_wifi, (r_fired == G_REV) && (r_action == A_SETTING))
    `TGH_ASSERT_IMPLIES(a_fire_beats_clock, i_clk, i_rst_n, r_out_valid && (r_fired != G_NONE), r_action != A_CLOCK)
    `TGH_ASSERT_NEXT(a_rev_clears_hold, i_clk, i_rst_n, o_pop && (n_fired == G_REV), r_hold_count == '0)

endmodule

// ===== design/tilt_gesture_hold_detector.sv =====
`timescale 1ns / 1ps
// Tilt gesture hold detector.
// Input channel: one beat per sensor tick (i_valid / o_stall) carrying the
// sample flag, accel x/y/z, gyro x/y and the widget-running flag. Every beat,
// sampled or not, produces exactly one result beat.
// Output channel: o_valid / i_stall carrying fired gesture, action, wifi
// reset request and the gesture left pending after that tick.
// Throughput: one beat per cycle while no stall holds the flow. The front
// classifies a beat against the thresholds in the cycle it is accepted and
// writes it into the queue; the back pops it, updates pending/hold/idle state
// and loads the output register, so a beat passes the queue and the output
// register before o_valid rises. The back's state update sets the rate.
// Stalls: the output register holds its beat while i_stall is high; the
// queue (QUEUE_DEPTH beats) keeps absorbing input, then o_stall rises.
// Reset (synchronous, i_rst_n low): config registers return to defaults,
// no gesture pending, counters cleared, queue and output register empty.
// Config: APB, register i at byte address 4*i, pready always high. Write
// only while the block holds no beat in flight.
module tilt_gesture_hold_detector #(
    parameter int QUEUE_DEPTH = tgh_pkg::TGH_QDEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tgh_pkg::TGH_ADDR_W-1:0]   paddr,
    input  logic [tgh_pkg::TGH_DATA_W-1:0]   pwdata,
    output logic [tgh_pkg::TGH_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_sample_valid,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_x,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_y,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_accel_z,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_gyro_x,
    input  logic [tgh_pkg::TGH_SAMPLE_W-1:0] i_gyro_y,
    input  logic                             i_widget_running,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [2:0]                       o_fired_gesture,
    output logic [3:0]                       o_action,
    output logic                             o_wifi_reset_request,
    output logic [2:0]                       o_pending_gesture_out
);
    import tgh_pkg::*;

    t_cfg   cfg;
    t_class front_class, q_head;
    logic   q_push, q_pop, q_full, q_nonempty;

    // Register file
    tgh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front: accept and compare against thresholds, pick the candidate gesture
    tgh_front u_front (
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_valid   (i_sample_valid),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_gyro_x         (i_gyro_x),
        .i_gyro_y         (i_gyro_y),
        .i_widget_running (i_widget_running),
        .i_cfg            (cfg),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_class          (front_class)
    );

    // Decoupling queue of classified beats
    tgh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_data     (front_class),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // Back: hold/fire/idle state machine and output register
    tgh_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (cfg),
        .i_q_nonempty          (q_nonempty),
        .i_head                (q_head),
        .o_pop                 (q_pop),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_fired_gesture       (o_fired_gesture),
        .o_action              (o_action),
        .o_wifi_reset_request  (o_wifi_reset_request),
        .o_pending_gesture_out (o_pending_gesture_out)
    );

endmodule

// ===== verif/tb_tilt_gesture_hold_detector.sv =====
`timescale 1ns / 1ps
module tb_tilt_gesture_hold_detector;
    import tgh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // One sensor tick as carried on the input channel.
    typedef struct packed {
        logic               sample_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic               widget_running;
    } t_sample;

    // One result beat.
    typedef struct packed {
        t_gesture fired;
        t_action  act;
        logic     wifi;
        t_gesture pend;
    } t_result;

    // ---------------------------------------------------------------
    // Clock, reset and block inputs. Everything starts at a known value.
    // ---------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [TGH_ADDR_W-1:0] paddr   = '0;
    logic [TGH_DATA_W-1:0] pwdata  = '0;
    logic [TGH_DATA_W-1:0] prdata;
    logic                  pready;

    logic    i_valid  = 1'b0;
    logic    i_stall  = 1'b0;
    t_sample cur_beat = '0;
    logic    o_stall;
    logic    o_valid;

    wire                    i_sample_valid   = cur_beat.sample_valid;
    wire [TGH_SAMPLE_W-1:0] i_accel_x        = cur_beat.accel_x;
    wire [TGH_SAMPLE_W-1:0] i_accel_y        = cur_beat.accel_y;
    wire [TGH_SAMPLE_W-1:0] i_accel_z        = cur_beat.accel_z;
    wire [TGH_SAMPLE_W-1:0] i_gyro_x         = cur_beat.gyro_x;
    wire [TGH_SAMPLE_W-1:0] i_gyro_y         = cur_beat.gyro_y;
    wire                    i_widget_running = cur_beat.widget_running;

    logic [2:0] o_fired_gesture;
    logic [3:0] o_action;
    logic       o_wifi_reset_request;
    logic [2:0] o_pending_gesture_out;

    tilt_gesture_hold_detector uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_sample_valid        (i_sample_valid),
        .i_accel_x             (i_accel_x),
        .i_accel_y             (i_accel_y),
        .i_accel_z             (i_accel_z),
        .i_gyro_x              (i_gyro_x),
        .i_gyro_y              (i_gyro_y),
        .i_widget_running      (i_widget_running),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_fired_gesture       (o_fired_gesture),
        .o_action              (o_action),
        .o_wifi_reset_request  (o_wifi_reset_request),
        .o_pending_gesture_out (o_pending_gesture_out)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------
    t_sample pending_samples[$];   // beats waiting for the driver
    t_result expected_results[$];  // predicted results, oldest first
    t_result want;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;    // stimulus asks for the long receiver hold-off
    logic long_hold      = 1'b0;    // receiver hold-off in progress
    logic beat_in_taken  = 1'b0;    // input beat accepted at the last rising edge

    int items_queued    = 0;
    int results_checked = 0;
    int gestures_fired  = 0;
    int clocks_launched = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Predictor's copy of the block: config registers plus detector state.
    t_cfg       cfg_model;
    t_gesture   pend_state = G_NONE;
    logic [8:0] hold_cnt   = '0;
    logic [15:0] idle_cnt  = '0;

    // ---------------------------------------------------------------
    // Gesture / idle predictor. Advances the model state by one tick.
    // ---------------------------------------------------------------
    function automatic t_result detector_step(input t_sample s);
        t_result    r;
        int         ax, ay, az, gx, gy, rt, at, gt;
        logic       held;
        logic [7:0] lim;
        logic [8:0] old_cnt;
        r.fired = G_NONE;
        r.act   = A_NONE;
        r.wifi  = 1'b0;
        ax = $signed(s.accel_x);
        ay = $signed(s.accel_y);
        az = $signed(s.accel_z);
        gx = $signed(s.gyro_x);
        gy = $signed(s.gyro_y);
        rt = cfg_model.reverse_threshold;
        at = cfg_model.tilt_accel_threshold;
        gt = cfg_model.tilt_gyro_threshold;

        if (s.sample_valid) begin
            if (pend_state == G_NONE) begin
                // priority: reverse, left, right, front, back
                hold_cnt = '0;
                if (az > rt)                 pend_state = G_REV;
                else if (ax > at && gy > gt)   pend_state = G_LEFT;
                else if (ax < -at && gy < -gt) pend_state = G_RIGHT;
                else if (ay < -at && gx > -gt) pend_state = G_FRONT;
                else if (ay > at && gx < gt)   pend_state = G_BACK;
            end else begin
                idle_cnt = '0;
                held = 1'b0;
                lim  = '0;
                case (pend_state)
                    G_REV: if (az > rt) begin
                        held = 1'b1;
                        lim  = cfg_model.reverse_hold_ticks;
                    end
                    G_LEFT: if (ax > at) begin
                        held = 1'b1;
                        lim  = cfg_model.side_hold_ticks;
                    end
                    G_RIGHT: if (ax < -at) begin
                        held = 1'b1;
                        lim  = cfg_model.side_hold_ticks;
                    end
                    G_FRONT: if (ay < -at) begin
                        held = 1'b1;
                        lim  = cfg_model.front_back_hold_ticks;
                    end
                    G_BACK: if (ay > at) begin
                        held = 1'b1;
                        lim  = cfg_model.front_back_hold_ticks;
                    end
                    default: ;
                endcase

                if (held) begin
                    // fire decision uses the count before the increment
                    old_cnt  = hold_cnt;
                    hold_cnt = (old_cnt < 9'd511) ? old_cnt + 9'd1 : 9'd511;
                    if (old_cnt >= {1'b0, lim}) begin
                        r.fired = pend_state;
                        case (pend_state)
                            G_REV: begin
                                hold_cnt = '0;
                                r.wifi   = 1'b1;
                                r.act    = A_SETTING;
                            end
                            G_LEFT:  r.act = s.widget_running ? A_CTL_LEFT  : A_PREV;
                            G_RIGHT: r.act = s.widget_running ? A_CTL_RIGHT : A_NEXT;
                            G_FRONT: r.act = s.widget_running ? A_CTL_FRONT : A_ENTER;
                            default: r.act = s.widget_running ? A_CTL_BACK  : A_NONE;
                        endcase
                        pend_state = G_NONE;
                    end
                end else begin
                    pend_state = G_NONE;
                end
            end
        end

        // idle counter runs on every non-widget tick, sample or not; wraps at 16 bits
        if (!s.widget_running) begin
            idle_cnt = idle_cnt + 16'd1;
            if (idle_cnt > cfg_model.idle_limit) begin
                idle_cnt = '0;
                if (r.fired == G_NONE) r.act = A_CLOCK;
            end
        end
        r.pend = pend_state;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int above(input int thr);
        return (thr < 32767) ? pick(thr + 1, 32767) : 32767;
    endfunction

    function automatic int below(input int thr);
        return pick(-32768, -thr - 1);
    endfunction

    // Mostly right on either side of +/-thr, sometimes full-range.
    function automatic logic [15:0] near_or_any(input int thr);
        int v;
        case ($urandom_range(5))
            0:       v = thr;
            1:       v = thr + 1;
            2:       v = -thr;
            3:       v = -thr - 1;
            default: v = $urandom_range(65535);
        endcase
        return v[15:0];
    endfunction

    function automatic t_sample mk(input int v, input int ax, input int ay, input int az,
                                   input int gx, input int gy, input int run);
        t_sample s;
        s.sample_valid   = v[0];
        s.accel_x        = ax[15:0];
        s.accel_y        = ay[15:0];
        s.accel_z        = az[15:0];
        s.gyro_x         = gx[15:0];
        s.gyro_y         = gy[15:0];
        s.widget_running = run[0];
        return s;
    endfunction

    function automatic t_sample noise_sample();
        t_sample s;
        s.sample_valid   = ($urandom_range(99) < 80);
        s.accel_x        = near_or_any(cfg_model.tilt_accel_threshold);
        s.accel_y        = near_or_any(cfg_model.tilt_accel_threshold);
        s.accel_z        = near_or_any(cfg_model.reverse_threshold);
        s.gyro_x         = near_or_any(cfg_model.tilt_gyro_threshold);
        s.gyro_y         = near_or_any(cfg_model.tilt_gyro_threshold);
        s.widget_running = ($urandom_range(99) < 40);
        return s;
    endfunction

    // Valid sample with every accel axis inside the thresholds: starts nothing,
    // and drops whatever gesture is pending.
    function automatic t_sample quiet_sample();
        t_sample s;
        int      at;
        at = cfg_model.tilt_accel_threshold;
        s = mk(1, pick(-at, at), pick(-at, at),
               pick(-int'(cfg_model.reverse_threshold), cfg_model.reverse_threshold),
               $urandom_range(65535), $urandom_range(65535), $urandom_range(99) < 40);
        return s;
    endfunction

    // Valid sample that keeps gesture g held; other fields are random.
    function automatic t_sample hold_sample(input t_gesture g);
        t_sample s;
        int      at;
        at = cfg_model.tilt_accel_threshold;
        s = noise_sample();
        s.sample_valid = 1'b1;
        case (g)
            G_REV:   s.accel_z = 16'(above(cfg_model.reverse_threshold));
            G_LEFT:  s.accel_x = 16'(above(at));
            G_RIGHT: s.accel_x = 16'(below(at));
            G_FRONT: s.accel_y = 16'(below(at));
            default: s.accel_y = 16'(above(at));
        endcase
        return s;
    endfunction

    task automatic offer(input t_sample s);
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // Detect beat, then holds; mostly long enough to fire, else cut short by
    // a quiet beat. Some no-sample beats are mixed into the hold.
    task automatic queue_gesture(input t_gesture g);
        t_sample s;
        int      at, gt, lim, n;
        at = cfg_model.tilt_accel_threshold;
        gt = cfg_model.tilt_gyro_threshold;
        s  = quiet_sample();
        case (g)
            G_REV: s.accel_z = 16'(above(cfg_model.reverse_threshold));
            G_LEFT: begin
                s.accel_x = 16'(above(at));
                s.gyro_y  = 16'(above(gt));
            end
            G_RIGHT: begin
                s.accel_x = 16'(below(at));
                s.gyro_y  = 16'(below(gt));
            end
            G_FRONT: begin
                s.accel_y = 16'(below(at));
                s.gyro_x  = 16'(pick(-gt + 1, 32767));
            end
            default: begin
                s.accel_y = 16'(above(at));
                s.gyro_x  = 16'(pick(-32768, gt - 1));
            end
        endcase
        offer(s);

        case (g)
            G_REV:          lim = cfg_model.reverse_hold_ticks;
            G_LEFT, G_RIGHT: lim = cfg_model.side_hold_ticks;
            default:        lim = cfg_model.front_back_hold_ticks;
        endcase
        n = ($urandom_range(99) < 70) ? lim + 1 : int'($urandom_range(lim));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 10) begin
                s = noise_sample();
                s.sample_valid = 1'b0;
                offer(s);
            end
            offer(hold_sample(g));
        end
        if (n <= lim) offer(quiet_sample());
    endtask

    // ---------------------------------------------------------------
    // APB register write: setup, then access; model updated at the write edge.
    // ---------------------------------------------------------------
    task automatic apb_write(input t_reg_idx idx, input int val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_REV_THR:   cfg_model.reverse_threshold     = val[14:0];
            REG_ACCEL_THR: cfg_model.tilt_accel_threshold  = val[14:0];
            REG_GYRO_THR:  cfg_model.tilt_gyro_threshold   = val[14:0];
            REG_REV_HOLD:  cfg_model.reverse_hold_ticks    = val[7:0];
            REG_SIDE_HOLD: cfg_model.side_hold_ticks       = val[7:0];
            REG_FB_HOLD:   cfg_model.front_back_hold_ticks = val[7:0];
            default:       cfg_model.idle_limit            = val[15:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_config(input int rt, input int at, input int gt, input int rh,
                                  input int sh, input int fh, input int il);
        apb_write(REG_REV_THR, rt);
        apb_write(REG_ACCEL_THR, at);
        apb_write(REG_GYRO_THR, gt);
        apb_write(REG_REV_HOLD, rh);
        apb_write(REG_SIDE_HOLD, sh);
        apb_write(REG_FB_HOLD, fh);
        apb_write(REG_IDLE_LIM, il);
    endtask

    task automatic random_phase(input int n_items, input int send_pct, input int stall_pct);
        int target;
        target = items_queued + n_items;
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (items_queued < target) begin
            if ($urandom_range(99) < 75) queue_gesture(t_gesture'($urandom_range(5, 1)));
            else offer(noise_sample());
        end
    endtask

    // Sender stays quiet until every predicted result is back, then lets the
    // pipeline settle before any register write.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
    endtask

    // ---------------------------------------------------------------
    // Driver: presents the head of pending_samples at the falling edge.
    // A stalled beat is left untouched until it is taken.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_in_taken) begin
            if (beat_in_taken) pending_samples.delete(0);
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid  <= 1'b1;
                cur_beat <= pending_samples[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here once the stimulus asks for it.
    initial begin
        wait (hold_req);
        long_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Receiver stall: random, or forced during the long hold-off.
    always @(negedge i_clk) begin
        i_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Input side: every accepted beat yields exactly one result, predicted here.
    always @(posedge i_clk) begin
        beat_in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            expected_results.push_back(detector_step(cur_beat));
    end

    // Monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no prediction outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("fired_gesture", o_fired_gesture, want.fired);
                check_field("action", o_action, want.act);
                check_field("wifi_reset_request", o_wifi_reset_request, want.wifi);
                check_field("pending_gesture_out", o_pending_gesture_out, want.pend);
                results_checked++;
                if (want.fired != G_NONE) gestures_fired++;
                if (want.act == A_CLOCK)  clocks_launched++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        cfg_model = '{TGH_RST_REV_THR, TGH_RST_ACCEL_THR, TGH_RST_GYRO_THR,
                      TGH_RST_REV_HOLD, TGH_RST_SIDE_HOLD, TGH_RST_FB_HOLD,
                      TGH_RST_IDLE_LIM};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset thresholds, short reverse hold so each gesture fits.
        apb_write(REG_REV_HOLD, 1);
        offer(mk(0, -32768, 32767, 32767, -32768, 32767, 1));   // no sample, extremes
        offer(mk(1, 0, 0, 0, 0, 0, 0));
        offer(mk(1, 0, 0, 32767, 0, 0, 0));                     // reverse detect
        offer(mk(1, 0, 0, 10001, 0, 0, 0));
        offer(mk(1, 0, 0, 32767, 0, 0, 0));                     // reverse fires
        offer(mk(1, 7001, 0, 0, 0, 2001, 1));                   // left detect
        offer(mk(1, 32767, 0, 0, 0, 0, 1));
        offer(mk(1, 7001, 0, 0, 0, 0, 1));
        offer(mk(1, 32767, 0, 0, 0, 0, 1));                     // left fires in widget
        offer(mk(1, -32768, 0, 0, 0, -32768, 0));               // right detect
        offer(mk(1, -7001, 0, 0, 0, 0, 0));
        offer(mk(1, -32768, 0, 0, 0, 0, 0));
        offer(mk(1, -7001, 0, 0, 0, 0, 0));                     // right fires
        offer(mk(1, 0, -32768, 0, 32767, 0, 1));                // front detect
        offer(mk(1, 0, -7001, 0, 0, 0, 1));
        offer(mk(1, 0, -32768, 0, 0, 0, 1));
        offer(mk(1, 0, -7001, 0, 0, 0, 1));                     // front fires
        offer(mk(1, 0, 32767, 0, -32768, 0, 0));                // back detect
        offer(mk(1, 0, 7001, 0, 0, 0, 0));
        offer(mk(1, 0, 32767, 0, 0, 0, 0));
        offer(mk(1, 0, 7001, 0, 0, 0, 0));                      // back fires, no action
        offer(mk(1, 7001, 0, 0, 0, 2001, 0));                   // left detect
        offer(mk(1, 7000, 0, 0, 0, 0, 0));                      // at threshold: dropped
        wait_drained();

        // Reset settings, no idling.
        program_config(10000, 7000, 2000, 10, 2, 2, 50);
        random_phase(300, 0, 0);
        wait_drained();

        // All zero: zero holds fire on the first hold, idle limit 0 clocks each
        // non-widget tick (and collides with fires).
        program_config(0, 0, 0, 0, 0, 0, 0);
        random_phase(250, 82, 0);
        wait_drained();

        // Small random settings, receiver stalling.
        program_config(pick(0, 20000), pick(0, 20000), pick(0, 20000),
                       pick(0, 4), pick(0, 4), pick(0, 4), pick(0, 20));
        random_phase(250, 0, 82);
        wait_drained();

        // Maximum thresholds, idle counter wraps so the clock never launches.
        program_config(32767, 32767, 32767, 1, 1, 1, 65535);
        random_phase(200, 17, 17);
        wait_drained();

        // Longest reverse and front/back holds.
        program_config(pick(0, 20000), pick(0, 20000), pick(0, 20000),
                       255, 0, 255, pick(0, 100));
        random_phase(350, 0, 0);
        wait_drained();

        // Longest side hold, idle limit 1.
        program_config(pick(0, 20000), pick(0, 20000), pick(0, 20000), 0, 255, 0, 1);
        random_phase(300, 82, 0);
        wait_drained();

        // Full-range random thresholds; the output is held off long enough for
        // the queue to fill and the input to stall while beats keep coming.
        program_config(pick(0, 32767), pick(0, 32767), pick(0, 32767),
                       pick(0, 6), pick(0, 6), pick(0, 6), pick(0, 200));
        random_phase(200, 0, 82);
        hold_req = 1'b1;
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_results.size()));
        $display("Ran %0d sensor ticks over 8 register settings and all idle/stall mixes,",
                 items_queued);
        $display("%0d results checked, %0d gestures fired, %0d clock launches, %0d mismatches",
                 results_checked, gestures_fired, clocks_launched, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
